// File: rtl/vcbrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the variable chunk byte ring buffer.
// Depends on nothing; vcbrb_ctrl, the top level and the testbench import it.
package vcbrb_pkg;

	localparam int MAX_CAPACITY = 4096;
	localparam int ADDR_W = $clog2(MAX_CAPACITY);
	localparam int POS_W = 13;
	localparam int OFF_W = 12;
	localparam int DATA_W = 8;
	localparam logic [POS_W-1:0] CAP_RESET = POS_W'(MAX_CAPACITY);

	typedef enum logic [1:0] {
		OP_WRITE_START = 2'd0,
		OP_WRITE_BYTE  = 2'd1,
		OP_RELEASE     = 2'd2,
		OP_READ_BYTE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_SPACE = 2'd1,
		STATUS_NO_DATA  = 2'd2
	} status_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		status_t          status;
		logic             rd_sel;
		logic [POS_W-1:0] writer;
		logic [POS_W-1:0] reader;
		logic             wrapped;
		logic             full;
		logic             empty;
	} result_t;

endpackage

// File: rtl/vcbrb_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module vcbrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule

// File: rtl/vcbrb_ctrl.sv
`timescale 1ns / 1ps
// Position, cursor and flag registers with the admission and release rules.
// Depends on vcbrb_pkg; issues the byte store request for write byte and in-range read byte requests.
module vcbrb_ctrl import vcbrb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [POS_W-1:0]  cfg_data,
	input  logic              accept,
	input  op_t               op,
	input  logic [POS_W-1:0]  len,
	input  logic [DATA_W-1:0] data_byte,
	input  logic [OFF_W-1:0]  off,
	output mem_req_t          mem_req,
	output result_t           result
);

	logic [POS_W-1:0]  cap_q, writer_q, reader_q;
	logic [ADDR_W-1:0] cursor_q;
	logic              wrapped_q, full_q, empty_q;

	logic [POS_W-1:0]  cap;
	logic [POS_W:0]    w_sum, w_wrap, r_sum, r_wrap;
	logic [POS_W-1:0]  used, rd_idx, rd_sum;
	logic [POS_W-1:0]  wb_next;
	logic [ADDR_W-1:0] wb_idx;
	logic [POS_W-1:0]  writer_n, reader_n;
	logic [ADDR_W-1:0] cursor_n;
	logic              wrapped_n, full_n, empty_n;
	status_t           status_n;

	always_comb begin
		if (cap_q == '0) begin
			cap = POS_W'(1);
		end else if (cap_q > CAP_RESET) begin
			cap = CAP_RESET;
		end else begin
			cap = cap_q;
		end
	end

	assign w_sum = {1'b0, writer_q} + {1'b0, len};
	assign w_wrap = w_sum - {1'b0, cap};
	assign r_sum = {1'b0, reader_q} + {1'b0, len};
	assign r_wrap = r_sum - {1'b0, cap};
	assign used = (reader_q <= writer_q) ? writer_q - reader_q : cap - reader_q + writer_q;
	assign rd_sum = reader_q + {1'b0, off};
	assign rd_idx = (rd_sum >= cap) ? rd_sum - cap : rd_sum;
	assign wb_idx = ({1'b0, cursor_q} >= cap) ? '0 : cursor_q;
	assign wb_next = {1'b0, wb_idx} + POS_W'(1);

	always_comb begin
		writer_n = writer_q;
		reader_n = reader_q;
		cursor_n = cursor_q;
		wrapped_n = wrapped_q;
		full_n = full_q;
		empty_n = empty_q;
		status_n = STATUS_OK;
		mem_req = '0;
		case (op)
			OP_WRITE_START: begin
				if (reader_q <= writer_q && w_sum <= {1'b0, cap}) begin
					writer_n = w_sum[POS_W-1:0];
				end else if (reader_q <= writer_q && w_wrap < {1'b0, reader_q}) begin
					writer_n = w_wrap[POS_W-1:0];
					wrapped_n = 1'b1;
				end else if (reader_q > writer_q && w_sum < {1'b0, reader_q}) begin
					writer_n = w_sum[POS_W-1:0];
				end else begin
					status_n = STATUS_NO_SPACE;
				end
				if (status_n == STATUS_OK) begin
					cursor_n = (writer_q >= cap) ? '0 : writer_q[ADDR_W-1:0];
					empty_n = 1'b0;
				end else begin
					full_n = 1'b1;
				end
			end
			OP_WRITE_BYTE: begin
				mem_req.wr_en = 1'b1;
				mem_req.addr = wb_idx;
				mem_req.wr_data = data_byte;
				cursor_n = (wb_next >= cap) ? '0 : wb_next[ADDR_W-1:0];
			end
			OP_RELEASE: begin
				if (reader_q <= writer_q && r_sum <= {1'b0, writer_q}) begin
					reader_n = r_sum[POS_W-1:0];
				end else if (reader_q > writer_q && r_sum <= {1'b0, cap}) begin
					reader_n = r_sum[POS_W-1:0];
				end else if (reader_q > writer_q && r_wrap <= {1'b0, writer_q}) begin
					reader_n = r_wrap[POS_W-1:0];
					wrapped_n = 1'b0;
				end else begin
					status_n = STATUS_NO_DATA;
				end
				if (status_n == STATUS_OK) begin
					full_n = 1'b0;
				end else begin
					empty_n = 1'b1;
				end
			end
			OP_READ_BYTE: begin
				if ({1'b0, off} < used) begin
					mem_req.rd_en = 1'b1;
					mem_req.addr = rd_idx[ADDR_W-1:0];
				end else begin
					status_n = STATUS_NO_DATA;
				end
			end
			default: begin
				status_n = STATUS_OK;
			end
		endcase
		if (!accept) begin
			mem_req = '0;
		end
	end

	assign result = '{
		status:  status_n,
		rd_sel:  mem_req.rd_en,
		writer:  writer_n,
		reader:  reader_n,
		wrapped: wrapped_n,
		full:    full_n,
		empty:   empty_n
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			writer_q <= '0;
			reader_q <= '0;
			cursor_q <= '0;
			wrapped_q <= 1'b0;
			full_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_data;
			writer_q <= '0;
			reader_q <= '0;
			cursor_q <= '0;
			wrapped_q <= 1'b0;
			full_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (accept) begin
			writer_q <= writer_n;
			reader_q <= reader_n;
			cursor_q <= cursor_n;
			wrapped_q <= wrapped_n;
			full_q <= full_n;
			empty_q <= empty_n;
		end
	end

	// The writer only ever falls behind the reader through a wrap.
	a_wrap_order: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q == (reader_q > writer_q))
		else $error("wrap flag disagrees with position order");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		writer_q <= cap && reader_q <= cap)
		else $error("position beyond capacity");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_wr_en && status_n != STATUS_OK |=> $stable(writer_q) && $stable(cursor_q))
		else $error("rejected request moved the writer");

endmodule

// File: rtl/variable_chunk_byte_ring_buffer.sv
`timescale 1ns / 1ps
// Top level of the variable chunk byte ring buffer: control, byte store, result stage.
// Depends on vcbrb_pkg, vcbrb_ctrl and vcbrb_ram.
//
//   channel   direction  handshake               payload
//   request   in         in_valid / in_stall     operation, length, data_byte, offset
//   result    out        out_valid / out_stall   status, read_data, positions, flags
//   config    in         cfg_wr_en               capacity_in_use
//
// One request per cycle while the result side keeps up. The edge that accepts a request
// registers its result and the byte store read into the read stage; that stage then moves
// into the output register, and out_valid rises when it does.
// Reset clears positions, cursor and flags at once; the byte store is not cleared.
// A stalled result holds the stage behind it, and in_stall rises while that stage is full
// and cannot move on.
module variable_chunk_byte_ring_buffer import vcbrb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [POS_W-1:0]  capacity_in_use,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        operation,
	input  logic [POS_W-1:0]  length,
	input  logic [DATA_W-1:0] data_byte,
	input  logic [OFF_W-1:0]  offset,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [DATA_W-1:0] read_data,
	output logic [POS_W-1:0]  writer_position,
	output logic [POS_W-1:0]  reader_position,
	output logic              wrap_flag,
	output logic              full_flag,
	output logic              empty_flag
);

	logic              accept;
	logic              s1_move;
	logic              valid_s1;
	result_t           result;
	result_t           res_s1;
	result_t           out_q;
	mem_req_t          mem_req;
	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] byte_q;
	logic              out_valid_q;

	assign s1_move = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign accept = in_valid && !in_stall;

	vcbrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_data  (capacity_in_use),
		.accept    (accept),
		.op        (op_t'(operation)),
		.len       (length),
		.data_byte (data_byte),
		.off       (offset),
		.mem_req   (mem_req),
		.result    (result)
	);

	vcbrb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.rd_en   (mem_req.rd_en),
		.addr    (mem_req.addr),
		.wr_data (mem_req.wr_data),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= result;
		end
		if (s1_move) begin
			out_q <= res_s1;
			byte_q <= res_s1.rd_sel ? rd_data : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign read_data = byte_q;
	assign writer_position = out_q.writer;
	assign reader_position = out_q.reader;
	assign wrap_flag = out_q.wrapped;
	assign full_flag = out_q.full;
	assign empty_flag = out_q.empty;

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach the read stage");

	a_hold_rd: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> rd_data === $past(rd_data))
		else $error("byte store output changed under a held read");

	a_move_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !s1_move)
		else $error("result overwritten while stalled");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the variable chunk byte ring buffer: a directed table, then
// random phases at several capacities; typed table rows are checked against their own result,
// the rest against a ring predictor. Depends on vcbrb_pkg and variable_chunk_byte_ring_buffer.
module testbench;
	import vcbrb_pkg::*;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic [OFF_W-1:0]  off;
	} ring_request_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] read_data;
		logic [POS_W-1:0]  writer;
		logic [POS_W-1:0]  reader;
		logic              wrap;
		logic              full;
		logic              empty;
	} ring_result_t;

	typedef struct {
		ring_request_t rq;
		bit            typed;
		ring_result_t  want;
	} directed_row_t;

	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 60;
	localparam int OWED_MAX = 12;
	localparam int phase_caps [PHASE_COUNT] = '{1, 4096, 5, 4095, 64, 2, 17, 300};

	directed_row_t directed_rows [24] = '{
		'{'{OP_READ_BYTE, 0, 0, 0}, 1, '{STATUS_NO_DATA, 0, 0, 0, 0, 0, 0}},
		'{'{OP_RELEASE, 0, 0, 0}, 1, '{STATUS_OK, 0, 0, 0, 0, 0, 0}},
		'{'{OP_RELEASE, 1, 0, 0}, 1, '{STATUS_NO_DATA, 0, 0, 0, 0, 0, 1}},
		'{'{OP_WRITE_START, 4096, 0, 0}, 1, '{STATUS_OK, 0, 4096, 0, 0, 0, 0}},
		'{'{OP_WRITE_START, 1, 0, 0}, 1, '{STATUS_NO_SPACE, 0, 4096, 0, 0, 1, 0}},
		'{'{OP_WRITE_BYTE, 0, 255, 0}, 0, '0},
		'{'{OP_WRITE_BYTE, 0, 0, 0}, 0, '0},
		'{'{OP_WRITE_BYTE, 0, 90, 0}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 0}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 2}, 0, '0},
		'{'{OP_RELEASE, 4096, 0, 0}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 0}, 1, '{STATUS_NO_DATA, 0, 4096, 4096, 0, 0, 0}},
		'{'{OP_WRITE_START, 3, 0, 0}, 0, '0},
		'{'{OP_WRITE_BYTE, 0, 129, 0}, 0, '0},
		'{'{OP_WRITE_BYTE, 0, 126, 0}, 0, '0},
		'{'{OP_WRITE_BYTE, 0, 60, 0}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 0}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 3}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 4095}, 0, '0},
		'{'{OP_RELEASE, 2, 0, 0}, 0, '0},
		'{'{OP_WRITE_START, 0, 0, 0}, 0, '0},
		'{'{OP_WRITE_START, 4095, 0, 0}, 0, '0},
		'{'{OP_RELEASE, 1, 0, 0}, 0, '0},
		'{'{OP_READ_BYTE, 0, 0, 0}, 0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [POS_W-1:0]  capacity_in_use = CAP_RESET;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        operation = 2'd0;
	logic [POS_W-1:0]  length = '0;
	logic [DATA_W-1:0] data_byte = '0;
	logic [OFF_W-1:0]  offset = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [DATA_W-1:0] read_data;
	logic [POS_W-1:0]  writer_position;
	logic [POS_W-1:0]  reader_position;
	logic              wrap_flag;
	logic              full_flag;
	logic              empty_flag;

	int ring_capacity;
	int ring_writer;
	int ring_reader;
	int ring_cursor;
	bit ring_wrapped;
	bit ring_full;
	bit ring_empty;
	logic [DATA_W-1:0] byte_image [MAX_CAPACITY];
	bit byte_valid [MAX_CAPACITY];

	ring_result_t awaited_results [$];
	int error_count = 0;
	int result_count = 0;
	int bytes_owed = 0;
	bit quiet_gaps = 1'b0;
	bit long_hold = 1'b0;

	variable_chunk_byte_ring_buffer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.capacity_in_use(capacity_in_use),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.length(length),
		.data_byte(data_byte),
		.offset(offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_data(read_data),
		.writer_position(writer_position),
		.reader_position(reader_position),
		.wrap_flag(wrap_flag),
		.full_flag(full_flag),
		.empty_flag(empty_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_ring();
		ring_writer = 0;
		ring_reader = 0;
		ring_cursor = 0;
		ring_wrapped = 1'b0;
		ring_full = 1'b0;
		ring_empty = 1'b0;
	endfunction

	function automatic ring_result_t ring_advance(input ring_request_t rq);
		ring_result_t res;
		int c, w, r, len, idx, used;
		bit taken;
		c = ring_capacity;
		w = ring_writer;
		r = ring_reader;
		len = int'(rq.len);
		res = '0;
		res.status = STATUS_OK;
		case (rq.op)
		OP_WRITE_START: begin
			taken = 1'b1;
			if (r <= w && w + len <= c) begin
				ring_writer = w + len;
			end else if (r <= w && w + len - c < r) begin
				ring_writer = w + len - c;
				ring_wrapped = 1'b1;
			end else if (r > w && w + len < r) begin
				ring_writer = w + len;
			end else begin
				taken = 1'b0;
			end
			if (taken) begin
				ring_cursor = (w >= c) ? 0 : w;
				ring_empty = 1'b0;
			end else begin
				ring_full = 1'b1;
				res.status = STATUS_NO_SPACE;
			end
		end
		OP_WRITE_BYTE: begin
			idx = (ring_cursor >= c) ? 0 : ring_cursor;
			byte_image[idx] = rq.data;
			byte_valid[idx] = 1'b1;
			ring_cursor = (idx + 1 >= c) ? 0 : idx + 1;
		end
		OP_RELEASE: begin
			taken = 1'b1;
			if (r <= w) begin
				if (r + len <= w) begin
					ring_reader = r + len;
				end else begin
					taken = 1'b0;
				end
			end else if (r + len <= c) begin
				ring_reader = r + len;
			end else if (r + len - c <= w) begin
				ring_reader = r + len - c;
				ring_wrapped = 1'b0;
			end else begin
				taken = 1'b0;
			end
			if (taken) begin
				ring_full = 1'b0;
			end else begin
				ring_empty = 1'b1;
				res.status = STATUS_NO_DATA;
			end
		end
		OP_READ_BYTE: begin
			used = (r <= w) ? w - r : c - r + w;
			if (int'(rq.off) < used) begin
				idx = r + int'(rq.off);
				if (idx >= c) begin
					idx = idx - c;
				end
				res.read_data = byte_image[idx];
			end else begin
				res.status = STATUS_NO_DATA;
			end
		end
		default: begin
		end
		endcase
		res.writer = POS_W'(ring_writer);
		res.reader = POS_W'(ring_reader);
		res.wrap = ring_wrapped;
		res.full = ring_full;
		res.empty = ring_empty;
		return res;
	endfunction

	// Most requests stay near the pointer edges; a read that would touch a never
	// written byte becomes a write byte instead.
	function automatic ring_request_t make_request();
		ring_request_t rq;
		int c, w, r, used, room, pick, idx;
		c = ring_capacity;
		w = ring_writer;
		r = ring_reader;
		used = (r <= w) ? w - r : c - r + w;
		room = (r <= w) ? c - w + ((r > 1) ? r - 1 : 0) : r - w - 1;
		rq.op = op_t'($urandom_range(0, 3));
		rq.len = POS_W'($urandom_range(0, MAX_CAPACITY));
		rq.data = DATA_W'($urandom_range(0, 255));
		rq.off = OFF_W'($urandom_range(0, MAX_CAPACITY - 1));
		if (bytes_owed > 0 && $urandom_range(0, 9) < 8) begin
			rq.op = OP_WRITE_BYTE;
			bytes_owed--;
			return rq;
		end
		pick = $urandom_range(0, 9);
		case (rq.op)
		OP_WRITE_START: begin
			if (pick < 6) begin
				rq.len = POS_W'($urandom_range(0, (room < 24) ? room : 24));
			end else if (pick == 6) begin
				rq.len = POS_W'(room);
			end else if (pick == 7) begin
				rq.len = POS_W'((room < MAX_CAPACITY) ? room + 1 : MAX_CAPACITY);
			end else if (pick == 8) begin
				rq.len = POS_W'(c);
			end
		end
		OP_RELEASE: begin
			if (pick < 6) begin
				rq.len = POS_W'($urandom_range(0, used));
			end else if (pick == 6) begin
				rq.len = POS_W'(used);
			end else if (pick == 7) begin
				rq.len = POS_W'((used < MAX_CAPACITY) ? used + 1 : MAX_CAPACITY);
			end
		end
		OP_READ_BYTE: begin
			if (pick < 7 && used > 0) begin
				rq.off = OFF_W'($urandom_range(0, used - 1));
			end else if (pick == 7 && used < MAX_CAPACITY) begin
				rq.off = OFF_W'(used);
			end
			if (int'(rq.off) < used) begin
				idx = r + int'(rq.off);
				if (idx >= c) begin
					idx = idx - c;
				end
				if (!byte_valid[idx]) begin
					rq.op = OP_WRITE_BYTE;
				end
			end
		end
		default: begin
		end
		endcase
		return rq;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] got,
			input logic [POS_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s got %0d expected %0d",
				result_count, name, got, want));
		end
	endtask

	task automatic issue_request(input ring_request_t rq, input ring_result_t want);
		int gap;
		awaited_results.push_back(want);
		gap = quiet_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= rq.op;
		length <= rq.len;
		data_byte <= rq.data;
		offset <= rq.off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic set_capacity(input int value);
		cfg_wr_en <= 1'b1;
		capacity_in_use <= POS_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ring_capacity = (value < 1) ? 1 : ((value > MAX_CAPACITY) ? MAX_CAPACITY : value);
		clear_ring();
	endtask

	initial begin : result_sink
		int hold;
		ring_result_t want;
		forever begin
			if (long_hold) begin
				hold = 300;
				long_hold = 1'b0;
			end else if (quiet_gaps) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 19);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (awaited_results.size() == 0) begin
				report_mismatch("result arrived with no request outstanding");
			end else begin
				want = awaited_results.pop_front();
				check_field("status", POS_W'(status), POS_W'(want.status));
				check_field("read_data", POS_W'(read_data), POS_W'(want.read_data));
				check_field("writer_position", writer_position, want.writer);
				check_field("reader_position", reader_position, want.reader);
				check_field("wrap_flag", POS_W'(wrap_flag), POS_W'(want.wrap));
				check_field("full_flag", POS_W'(full_flag), POS_W'(want.full));
				check_field("empty_flag", POS_W'(empty_flag), POS_W'(want.empty));
			end
			result_count++;
		end
	end

	initial begin : request_source
		ring_request_t rq;
		ring_result_t res;
		int n;
		ring_capacity = MAX_CAPACITY;
		clear_ring();
		foreach (byte_valid[i]) begin
			byte_valid[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			rq = directed_rows[i].rq;
			res = ring_advance(rq);
			if (directed_rows[i].typed) begin
				res = directed_rows[i].want;
			end
			issue_request(rq, res);
		end
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			in_valid <= 1'b0;
			while (awaited_results.size() != 0) @(posedge clk);
			set_capacity(phase_caps[phase]);
			quiet_gaps = (phase == 1) || (phase == 3);
			if (phase == 1) begin
				long_hold = 1'b1;
			end
			bytes_owed = 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				rq = make_request();
				res = ring_advance(rq);
				if (rq.op == OP_WRITE_START && res.status == STATUS_OK) begin
					bytes_owed = (int'(rq.len) < OWED_MAX) ? int'(rq.len) : OWED_MAX;
				end
				issue_request(rq, res);
			end
		end
		in_valid <= 1'b0;
		quiet_gaps = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Timeout: results still outstanding");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
rtl/vcbrb_pkg.sv
rtl/vcbrb_ram.sv
rtl/vcbrb_ctrl.sv
rtl/variable_chunk_byte_ring_buffer.sv
verif/testbench.sv
